>>> hw/rtl/wpb_pkg.sv
// Shared types and constants for the white-patch balance block.
`default_nettype none
package wpb_pkg;

  localparam int unsigned CHANNELS = 3;
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned PROD_W   = 2 * PIX_W;
  localparam int unsigned DIV_STEPS = PIX_W;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [PROD_W-1:0] prod_t;

  localparam pix_t FULL_SCALE = '1;

  // Register indexes of the configuration port.
  typedef enum logic [1:0] {
    REG_REF_C0 = 2'd0,
    REG_REF_C1 = 2'd1,
    REG_REF_C2 = 2'd2
  } reg_idx_t;

endpackage
`default_nettype wire

>>> hw/rtl/wpb_lane.sv
// One channel lane: pipelined restoring divider computing min(255, pix*255/ref).
`default_nettype none
module wpb_lane
  import wpb_pkg::*;
(
  input  wire logic clk,
  input  wire logic en,
  input  wire pix_t pix,
  input  wire pix_t refv,
  output pix_t      bal
);

  // Stage 0 holds the captured operands, stage k holds k quotient bits.
  pix_t rem  [0:DIV_STEPS];
  pix_t low  [0:DIV_STEPS];
  pix_t dvs  [0:DIV_STEPS];
  pix_t quo  [0:DIV_STEPS];
  logic sat  [0:DIV_STEPS];
  logic zero [0:DIV_STEPS];

  pix_t rem_next [1:DIV_STEPS];
  pix_t quo_next [1:DIV_STEPS];

  prod_t prod;

  // pix * 255 as a shift and subtract.
  assign prod = {pix, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, pix};

  always_comb begin
    logic [PIX_W:0] trial;
    logic           ge;
    for (int s = 1; s <= DIV_STEPS; s++) begin
      trial = {rem[s-1], low[s-1][PIX_W-1]};
      ge    = trial >= {1'b0, dvs[s-1]};
      rem_next[s] = ge ? pix_t'(trial - {1'b0, dvs[s-1]}) : trial[PIX_W-1:0];
      quo_next[s] = {quo[s-1][PIX_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Upper product byte is below ref whenever pix < ref, so quotient fits 8 bits.
      rem[0]  <= prod[PROD_W-1:PIX_W];
      low[0]  <= prod[PIX_W-1:0];
      dvs[0]  <= refv;
      quo[0]  <= '0;
      sat[0]  <= (pix >= refv);
      zero[0] <= (pix == '0);
      for (int s = 1; s <= DIV_STEPS; s++) begin
        rem[s]  <= rem_next[s];
        low[s]  <= {low[s-1][PIX_W-2:0], 1'b0};
        dvs[s]  <= dvs[s-1];
        quo[s]  <= quo_next[s];
        sat[s]  <= sat[s-1];
        zero[s] <= zero[s-1];
      end
    end
  end

  // Zero pixel wins over saturation (covers ref == 0 with pix == 0).
  assign bal = zero[DIV_STEPS] ? '0 :
               sat[DIV_STEPS]  ? FULL_SCALE : quo[DIV_STEPS];

endmodule
`default_nettype wire

>>> hw/rtl/wpb_out.sv
// Merge stage: gathers the lane results into the registered output beat.
`default_nettype none
module wpb_out
  import wpb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire pix_t lane_bal [0:CHANNELS-1],
  output logic      out_valid,
  output logic [CHANNELS*PIX_W-1:0] out_data
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < CHANNELS; c++) begin
        out_data[c*PIX_W +: PIX_W] <= lane_bal[c];
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/white_patch_balance_core.sv
// White-patch white balance: three channel lanes, each min(255, pix*255/ref).
// Pipeline: operand capture, 8 divider steps, output register. Throughput:
// one pixel per cycle while m_tready stays high;
// the pipeline holds as a whole when the output beat is not taken.
// Reset (rst, synchronous): references return to 255, all pipeline valids clear.
`default_nettype none
module white_patch_balance_core
  import wpb_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration: index 0..2 selects ref_c0..ref_c2, other indexes ignored.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [7:0]  cfg_data,
  // Input stream.
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // pix_c0 [7:0], pix_c1 [15:8], pix_c2 [23:16]
  // Output stream.
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // bal_c0 [7:0], bal_c1 [15:8], bal_c2 [23:16]
);

  pix_t ref_val  [0:CHANNELS-1];
  pix_t lane_bal [0:CHANNELS-1];

  // Valid bit per pipeline stage: stage 0 is the operand capture.
  logic vld [0:DIV_STEPS];
  logic adv;

  // Whole pipeline moves when the output slot is free or being drained.
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Reference registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        ref_val[c] <= FULL_SCALE;
      end
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_REF_C0: ref_val[0] <= cfg_data;
        REG_REF_C1: ref_val[1] <= cfg_data;
        REG_REF_C2: ref_val[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Beat valid travels alongside the lane data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= DIV_STEPS; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= s_tvalid;
      for (int s = 1; s <= DIV_STEPS; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  // One divider lane per color channel.
  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    wpb_lane u_lane (
      .clk  (clk),
      .en   (adv),
      .pix  (s_tdata[c*PIX_W +: PIX_W]),
      .refv (ref_val[c]),
      .bal  (lane_bal[c])
    );
  end

  // Output register merges the lanes into one beat.
  wpb_out u_out (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vld[DIV_STEPS]),
    .lane_bal  (lane_bal),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule
`default_nettype wire

>>> tb/sv/white_patch_balance_core_tb.sv
// Self-checking testbench for white_patch_balance_core: scoreboard class and stimulus.
`timescale 1ns / 100ps
module white_patch_balance_core_tb;
  import wpb_pkg::*;

  // cfg_addr is two bits wide, so index 3 exists on the port but selects no register
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int HOLD_CYCLES  = 300;      // long output hold-off, fills the pipeline
  localparam int DRAIN_CYCLES = 20;       // extra wait after the scoreboard has drained
  localparam int CYCLE_LIMIT  = 400000;   // watchdog
  localparam int PHASE_BEATS  = 250;

  // Scoreboard: holds a copy of the white references, predicts each balanced
  // pixel when its input beat is accepted and checks output beats in order.
  class balance_scoreboard;
    pix_t        white_ref[CHANNELS];
    logic [23:0] bal_expected[$];
    int          errors;
    int          checked;

    function new();
      foreach (white_ref[i]) white_ref[i] = FULL_SCALE;
      errors  = 0;
      checked = 0;
    endfunction

    // writes to an index with no register are dropped
    function void set_ref(logic [1:0] idx, pix_t val);
      if (idx <= REG_REF_C2) white_ref[idx] = val;
    endfunction

    // min(255, floor(pix * 255 / white)); zero white saturates any nonzero pixel
    function pix_t scale_channel(pix_t pix, pix_t white);
      prod_t quot;
      if (white == '0) return (pix != '0) ? FULL_SCALE : pix_t'(0);
      quot = (prod_t'(pix) * prod_t'(FULL_SCALE)) / prod_t'(white);
      return (quot > prod_t'(FULL_SCALE)) ? FULL_SCALE : quot[PIX_W-1:0];
    endfunction

    function void note_pixel(logic [23:0] pix);
      logic [23:0] bal;
      for (int ch = 0; ch < CHANNELS; ch++)
        bal[ch*PIX_W +: PIX_W] = scale_channel(pix[ch*PIX_W +: PIX_W], white_ref[ch]);
      bal_expected.push_back(bal);
    endfunction

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_beat(logic [23:0] bal);
      logic [23:0] want;
      if (bal_expected.size() == 0) begin
        flag($sformatf("output beat 0x%06h with no pixel outstanding", bal));
        return;
      end
      want = bal_expected.pop_front();
      checked++;
      for (int ch = 0; ch < CHANNELS; ch++)
        if (bal[ch*PIX_W +: PIX_W] !== want[ch*PIX_W +: PIX_W])
          flag($sformatf("beat %0d bal_c%0d: expected %0d, got %0d", checked, ch,
                         want[ch*PIX_W +: PIX_W], bal[ch*PIX_W +: PIX_W]));
    endfunction

    function int pending();
      return bal_expected.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [7:0]  cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;    // pix_c0 [7:0], pix_c1 [15:8], pix_c2 [23:16]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;    // bal_c0 [7:0], bal_c1 [15:8], bal_c2 [23:16]

  balance_scoreboard sb = new();

  // flow-control mix, changed per phase by the main sequence
  int idle_pct  = 0;
  int stall_pct = 0;
  bit hold_start = 1'b0;
  int cycles = 0;

  white_patch_balance_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles, %0d beats outstanding",
               cycles, sb.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  // Output side: ready is chosen at the falling edge. A hold-off request forces
  // ready low while hold_cnt counts down from HOLD_CYCLES and the sender keeps pushing.
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_start) begin
        hold_cnt   = HOLD_CYCLES;
        hold_start = 1'b0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Output beats are taken at the rising edge, before the DUT's registers move.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_beat(m_tdata);
  end

  // One input beat. tvalid is only lowered for a gap, never lowered and raised
  // in the same step; the caller drops it with stream_idle when done.
  task automatic send_pixel(input logic [23:0] pix);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= 24'($urandom);
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
    sb.note_pixel(pix);
  endtask

  task automatic stream_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Register write; the scoreboard copy follows at the same edge.
  task automatic write_ref(input logic [1:0] idx, input pix_t val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_ref(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_refs(input pix_t r0, input pix_t r1, input pix_t r2);
    stream_idle();
    wait_drained();
    write_ref(REG_REF_C0, r0);
    write_ref(REG_REF_C1, r1);
    write_ref(REG_REF_C2, r2);
  endtask

  // Biased channel value: boundaries around the reference show up often.
  function automatic pix_t pick_channel(pix_t white);
    case ($urandom_range(7))
      0:       return '0;
      1:       return FULL_SCALE;
      2:       return white;
      3:       return white - pix_t'(1);
      4:       return white + pix_t'(1);
      default: return pix_t'($urandom_range(255));
    endcase
  endfunction

  initial begin
    pix_t refs[CHANNELS];
    int   settings;

    rst      = 1'b1;
    cfg_we   = 1'b0;
    cfg_addr = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    settings = 1;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- directed: reset references (all 255), pixel extremes
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h01807F);
    send_pixel(24'hFE0102);

    // zero reference, reference of one, mid reference; values above reference saturate
    set_refs(8'd0, 8'd1, 8'd128);
    settings++;
    send_pixel(24'h000000);
    send_pixel(24'h800101);
    send_pixel(24'h8100FF);
    send_pixel(24'h7F0200);
    send_pixel(24'hFFFF07);

    // write to the unused index must leave the references alone
    stream_idle();
    wait_drained();
    write_ref(REG_NONE, 8'd7);
    send_pixel(24'h808080);
    send_pixel(24'h7F0001);

    // full-scale and near-full-scale references, zero in the last channel
    set_refs(8'd255, 8'd254, 8'd0);
    settings++;
    send_pixel(24'h00FE01);
    send_pixel(24'hFFFDFF);
    send_pixel(24'h01FF00);
    send_pixel(24'h00FFFE);

    // --- random phases, one flow-control mix and one reference setting each
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          idle_pct = 0;  stall_pct = 0;
          refs[0] = 8'd200; refs[1] = 8'd100; refs[2] = 8'd50;
        end
        1: begin
          idle_pct = 71; stall_pct = 0;
          refs[0] = 8'd0; refs[1] = 8'd255; refs[2] = 8'd1;
        end
        2: begin
          idle_pct = 0;  stall_pct = 71;
          foreach (refs[i]) refs[i] = pix_t'($urandom_range(255));
        end
        default: begin
          idle_pct = 12; stall_pct = 12;
          foreach (refs[i]) refs[i] = pix_t'($urandom_range(255));
        end
      endcase
      set_refs(refs[0], refs[1], refs[2]);
      settings++;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // long output stall with the input still offering: backpressure reaches s_tready
        if (ph == 0 && n == 40) hold_start = 1'b1;
        // sender pause until the pipeline is empty, then resume
        if (ph == 1 && n == PHASE_BEATS / 2) begin
          stream_idle();
          wait_drained();
        end
        send_pixel({pick_channel(refs[2]), pick_channel(refs[1]), pick_channel(refs[0])});
      end
    end

    stream_idle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.flag($sformatf("%0d expected beats never arrived", sb.pending()));

    $display("Checked %0d balanced pixels over %0d reference settings, incl. zero and full scale.",
             sb.checked, settings);
    $display("Flow control: free-running, sparse input, heavy stall, mixed, long hold and drain.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
